// ===== rtl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit field packer package
// Shared widths, controller state type and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bfp_pkg;

  // Fixed widths of the word fields.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned BYTE_W  = 8;

  // Request codes carried in req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } bfp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted input word
    logic step;  // run one fill or flush step
  } bfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a byte this cycle
    logic is_flush;   // held request is a flush
    logic last_step;  // this step consumes the remaining bits
  } bfp_status_t;

endpackage

// ===== rtl/bfp_in_if.sv =====
// ----------------------------------------------------------------------------
// Bit field packer input channel
// Valid/ready channel that carries one write or flush request word.
// ----------------------------------------------------------------------------
interface bfp_in_if
  import bfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COUNT_W-1:0] bit_count;
  logic [VALUE_W-1:0] field_value;

  modport source (output valid, output req_type, output bit_count,
                  output field_value, input ready);
  modport sink   (input valid, input req_type, input bit_count,
                  input field_value, output ready);
endinterface

// ===== rtl/bfp_out_if.sv =====
// ----------------------------------------------------------------------------
// Bit field packer output channel
// Valid/ready channel that carries one packed byte and its last flag.
// ----------------------------------------------------------------------------
interface bfp_out_if
  import bfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/bfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bit field packer controller
// Accepts one request word at a time and sequences the fill steps of the
// datapath until the request is fully consumed.
// ----------------------------------------------------------------------------
module bfp_ctrl
  import bfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bfp_status_t stat,
  output bfp_cmd_t    cmd
);

  bfp_state_t state;
  bfp_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // No word is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // A step may emit a byte, so it waits for room in the output register.
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.is_flush || stat.last_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bfp_dpath.sv =====
// ----------------------------------------------------------------------------
// Bit field packer datapath
// Holds the request, the pending byte and its one-hot fill position, fills
// up to one byte per step and drives the output register.
// ----------------------------------------------------------------------------
module bfp_dpath
  import bfp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bfp_cmd_t           cmd,
  output bfp_status_t        stat,
  input  logic               req_type,
  input  logic [COUNT_W-1:0] bit_count,
  input  logic [VALUE_W-1:0] field_value,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  localparam int unsigned CW = $clog2(MAX_FIELD_BITS + 1);

  // Held request and packing state.
  logic               lsb_first;
  logic               req_flush;
  logic [CW-1:0]      rem;
  logic [VALUE_W-1:0] val;
  logic [7:0]         pend;
  logic [7:0]         pos;

  // Step results.
  logic [2:0]    pos_idx;
  logic [2:0]    start;
  logic [3:0]    slots;
  logic [3:0]    take;
  logic [3:0]    end_idx;
  logic          full;
  logic [7:0]    mask;
  logic [7:0]    bits;
  logic [7:0]    bits_rev;
  logic [7:0]    fill;
  logic [7:0]    merged;
  logic [7:0]    pos_next;
  logic [CW-1:0] rem_next;
  logic          emit;

  // Position encoder for the one-hot fill position.
  always_comb begin
    pos_idx = '0;
    for (int b = 0; b < 8; b++) begin
      if (pos[b]) begin
        pos_idx = 3'(b);
      end
    end
  end

  // Free slots in the current byte and the number of bits this step takes.
  always_comb begin
    if (lsb_first) begin
      start = (pos == '0) ? 3'd0 : pos_idx;
      slots = 4'd8 - {1'b0, start};
    end else begin
      start = (pos == '0) ? 3'd7 : pos_idx;
      slots = {1'b0, start} + 4'd1;
    end
    if (rem < CW'(slots)) begin
      take = 4'(rem);
    end else begin
      take = slots;
    end
    full = (take == slots);
  end

  // Place the low bits of the value into the free slots of the byte.
  always_comb begin
    mask = 8'((9'd1 << take) - 9'd1);
    bits = val[7:0] & mask;
    for (int b = 0; b < 8; b++) begin
      bits_rev[b] = bits[7-b];
    end
    if (lsb_first) begin
      fill    = 8'(bits << start);
      end_idx = {1'b0, start} + take;
    end else begin
      fill    = bits_rev >> (3'd7 - start);
      end_idx = {1'b0, start} - take;
    end
    merged = pend | fill;
    if (take == 4'd0) begin
      pos_next = pos;
    end else if (full) begin
      pos_next = '0;
    end else begin
      pos_next = 8'(9'd1 << end_idx[2:0]);
    end
    rem_next = rem - CW'(take);
  end

  assign emit = cmd.step && (req_flush ? (pos != '0) : full);

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.is_flush  = req_flush;
  assign stat.last_step = (rem_next == '0);

  // Bit order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first <= 1'b1;
    end else if (cfg_wr_en) begin
      lsb_first <= cfg_wr_data;
    end
  end

  // Request capture and per-step update of the remaining bits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_flush <= (req_type == REQ_FLUSH);
      val       <= field_value;
      if (32'(bit_count) > MAX_FIELD_BITS) begin
        rem <= CW'(MAX_FIELD_BITS);
      end else begin
        rem <= CW'(bit_count);
      end
    end else if (cmd.step) begin
      val <= val >> take;
      rem <= rem_next;
    end
  end

  // Pending byte and fill position.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      pos  <= '0;
    end else if (cmd.step) begin
      if (req_flush) begin
        pend <= '0;
        pos  <= '0;
      end else begin
        pend <= full ? 8'd0 : merged;
        pos  <= pos_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (req_flush) begin
        out_byte <= pend;
        out_last <= 1'b1;
      end else begin
        out_byte <= merged;
        out_last <= (rem_next < CW'(8));
      end
    end
  end

  // The fill position is one-hot or cleared.
  a_pos_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pos))
    else $error("fill position is not one-hot");

  // A flush step always leaves the packer with nothing pending.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.step && req_flush |=> (pos == '0) && (pend == '0))
    else $error("flush left bits pending");

  // A write step that fills the byte presents it on the output.
  a_full_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !req_flush && full |=> out_valid && (pos == '0))
    else $error("completed byte was not emitted");

endmodule

// ===== rtl/bit_field_packer_core.sv =====
// Sequencing: a request word is captured when it is accepted in ST_IDLE; each
// byte it completes is loaded into the output register by the ST_BUSY step
// that fills it, and a step waits while the output register is full. A write
// takes one step per byte it touches, at least one (up to five for a 32-bit
// field), a flush a single step; a new word is taken only after the last step.
// Reset (rst, synchronous): bit order lsb_first, nothing pending, output empty.
// ----------------------------------------------------------------------------
// Bit field packer core
// Packs variable-width bit fields into a byte stream with a selectable fill
// order; a flush request emits the partially filled byte.
// ----------------------------------------------------------------------------
module bit_field_packer_core
  import bfp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  bfp_in_if.sink    in_ch,
  bfp_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  bfp_cmd_t    cmd;
  bfp_status_t stat;

  // Request sequencing.
  bfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Packing datapath and output register.
  bfp_dpath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (in_ch.req_type),
    .bit_count   (in_ch.bit_count),
    .field_value (in_ch.field_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .out_last    (out_ch.last)
  );

endmodule

// ===== tb/sv/bfp_stream_checker.sv =====
// ----------------------------------------------------------------------------
// Bit field packer stream checker
// Watches the request and byte channels and the order register port. It
// keeps its own copy of the pending byte and fill position, predicts the
// bytes each accepted request word produces, and compares every accepted
// output word with the oldest prediction.
// ----------------------------------------------------------------------------
module bfp_stream_checker
  import bfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bfp_in_if    in_mon,
  bfp_out_if   out_mon,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic end_of_test,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_BITS_CAP = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // Shadow of the packer state and its order register.
  logic              fill_upward;
  logic [BYTE_W-1:0] gathered_bits;
  logic [BYTE_W-1:0] fill_mask;
  packed_byte_t      expected_bytes[$];

  int mismatches  = 0;
  int queue_depth = 0;
  bit ended       = 1'b0;

  assign fail_count  = mismatches;
  assign outstanding = queue_depth;

  // Print one line per mismatch and count it.
  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Appends the bytes that one request word completes to the expected list.
  function automatic void pack_word(input logic               req,
                                    input logic [COUNT_W-1:0] cnt,
                                    input logic [VALUE_W-1:0] val);
    logic [BYTE_W-1:0]  done_bytes[$];
    logic [VALUE_W-1:0] bits_left;
    int                 n_bits;
    bits_left = val;
    if (req == REQ_FLUSH) begin
      // A flush only emits when some bits are waiting.
      if (fill_mask != '0) begin
        done_bytes.push_back(gathered_bits);
      end
      fill_mask     = '0;
      gathered_bits = '0;
    end else begin
      // Counts above the field width saturate; the direction is read per bit.
      n_bits = (cnt > FIELD_BITS_CAP) ? FIELD_BITS_CAP : int'(cnt);
      for (int i = 0; i < n_bits; i++) begin
        if (fill_mask == '0) begin
          fill_mask = fill_upward ? 8'h01 : 8'h80;
        end
        if (bits_left[0]) begin
          gathered_bits = gathered_bits | fill_mask;
        end
        fill_mask = fill_upward ? (fill_mask << 1) : (fill_mask >> 1);
        bits_left = bits_left >> 1;
        if (fill_mask == '0) begin
          done_bytes.push_back(gathered_bits);
          gathered_bits = '0;
        end
      end
    end
    foreach (done_bytes[k]) begin
      expected_bytes.push_back('{data: done_bytes[k],
                                 last: (k == done_bytes.size() - 1)});
    end
  endfunction

  // Output words are checked before the request accepted at the same edge
  // is predicted, since a request cannot produce a byte in its own cycle.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      fill_upward   = 1'b1;
      gathered_bits = '0;
      fill_mask     = '0;
      expected_bytes.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b",
                           out_mon.out_byte, out_mon.last));
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.out_byte !== want.data) begin
            report($sformatf("byte %02h, expected %02h", out_mon.out_byte, want.data));
          end
          if (out_mon.last !== want.last) begin
            report($sformatf("last %0b on byte %02h, expected %0b",
                             out_mon.last, want.data, want.last));
          end
        end
      end
      if (cfg_wr_en) begin
        fill_upward = cfg_wr_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        pack_word(in_mon.req_type, in_mon.bit_count, in_mon.field_value);
      end
      // Anything still waiting at the end never arrived.
      if (end_of_test && !ended) begin
        ended = 1'b1;
        if (expected_bytes.size() != 0) begin
          report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        end
      end
    end
    queue_depth <= expected_bytes.size();
  end

endmodule

// ===== tb/sv/tb_bit_field_packer_core.sv =====
// ----------------------------------------------------------------------------
// Bit field packer core testbench
// Drives directed and random write and flush words into the packer under
// both fill orders, with random idling on both channels and one long output
// stall, while the stream checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_bit_field_packer_core
  import bfp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CLK_HALF        = 5;
  localparam int   RESET_CYCLES    = 12;
  localparam int   SETTLE_CYCLES   = 12;
  localparam int   DRAIN_LIMIT     = 5000;
  localparam int   WORDS_PER_PHASE = 83;
  localparam int   STALL_CYCLES    = 150;
  localparam logic ORDER_LSB_FIRST = 1'b1;
  localparam logic ORDER_MSB_FIRST = 1'b0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic end_of_test;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   fail_count;
  int   outstanding;

  bfp_in_if  in_ch ();
  bfp_out_if out_ch ();

  bit_field_packer_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bfp_stream_checker u_stream_chk (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .end_of_test (end_of_test),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the stream hangs.
  initial begin
    #2ms;
    $display("bit_field_packer_core test failed");
    $finish;
  end

  // Byte receiver: random idling, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request word and returns at the edge that accepts it. Valid
  // stays high so back-to-back words need no second assignment in one step.
  task automatic send_word(input logic               req,
                           input logic [COUNT_W-1:0] cnt,
                           input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.bit_count   <= cnt;
    in_ch.field_value <= val;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // Mostly ordinary writes, with flushes, empty writes and oversized counts.
  task automatic send_random_word();
    int                 pick;
    logic [COUNT_W-1:0] cnt;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_word(REQ_FLUSH, COUNT_W'($urandom), $urandom);
    end else begin
      if (pick < 20) begin
        cnt = '0;
      end else if (pick < 30) begin
        cnt = COUNT_W'($urandom_range(33, 63));
      end else if (pick < 40) begin
        cnt = COUNT_W'(8 * $urandom_range(1, 4));
      end else begin
        cnt = COUNT_W'($urandom_range(1, 32));
      end
      send_word(REQ_WRITE, cnt, $urandom);
    end
  endtask

  // Stops offering, waits for every predicted byte, then lets the core settle.
  task automatic wait_idle();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Changes the fill order once the core is quiet.
  task automatic set_order(input logic order);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_WRITE;
    in_ch.bit_count   <= '0;
    in_ch.field_value <= '0;
    out_ch.ready      <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= ORDER_LSB_FIRST;
    end_of_test       <= 1'b0;
    hold_cycles   = 0;
    send_idle_pct = 7;
    recv_idle_pct = 51;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words in the reset order: empty write, full-width values,
    // byte crossings, oversized counts and flushes with and without bits.
    send_word(REQ_WRITE, 6'd0,  32'hFFFF_FFFF);
    send_word(REQ_WRITE, 6'd1,  32'h0000_0001);
    send_word(REQ_WRITE, 6'd7,  32'h0000_0055);
    send_word(REQ_WRITE, 6'd32, 32'hFFFF_FFFF);
    send_word(REQ_WRITE, 6'd32, 32'h0000_0000);
    send_word(REQ_WRITE, 6'd3,  32'h0000_0005);
    send_word(REQ_WRITE, 6'd32, 32'hA5A5_5A5A);
    send_word(REQ_FLUSH, 6'd63, 32'hFFFF_FFFF);
    send_word(REQ_FLUSH, 6'd0,  32'h0000_0000);
    send_word(REQ_WRITE, 6'd63, 32'hDEAD_BEEF);
    send_word(REQ_WRITE, 6'd33, 32'h1234_5678);
    send_word(REQ_WRITE, 6'd8,  32'h0000_0080);
    send_word(REQ_FLUSH, 6'd32, 32'h8000_0000);
    send_word(REQ_WRITE, 6'd5,  32'h0000_001F);

    // Switch the order with a byte partly filled, then run the other order.
    set_order(ORDER_MSB_FIRST);
    send_word(REQ_WRITE, 6'd6,  32'h0000_002A);
    send_word(REQ_WRITE, 6'd17, 32'h0001_3C96);
    send_word(REQ_FLUSH, 6'd1,  32'h0000_0001);
    send_word(REQ_WRITE, 6'd1,  32'h0000_0001);
    send_word(REQ_WRITE, 6'd32, 32'h0F0F_0F0F);
    send_word(REQ_FLUSH, 6'd0,  32'h0000_0000);
    send_word(REQ_WRITE, 6'd32, 32'hFFFF_FFFF);
    send_word(REQ_FLUSH, 6'd0,  32'h0000_0000);

    // Random phases: sender light and receiver heavy idling, then the other
    // way round, then none, starting with a long output stall.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 51;
          set_order(ORDER_MSB_FIRST);
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 7;
          set_order(ORDER_LSB_FIRST);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_order(ORDER_MSB_FIRST);
          hold_cycles = STALL_CYCLES;
        end
      endcase
      repeat (WORDS_PER_PHASE) send_random_word();
    end

    wait_idle();
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("bit_field_packer_core test passed");
    end else begin
      $display("bit_field_packer_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bfp_pkg.sv
rtl/bfp_in_if.sv
rtl/bfp_out_if.sv
rtl/bfp_ctrl.sv
rtl/bfp_dpath.sv
rtl/bit_field_packer_core.sv
tb/sv/bfp_stream_checker.sv
tb/sv/tb_bit_field_packer_core.sv
